@@ rtl/uart_command_recognizer_macros.svh @@
// assertion macros for the uart command recognizer
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef UART_COMMAND_RECOGNIZER_MACROS_SVH
`define UART_COMMAND_RECOGNIZER_MACROS_SVH
`ifndef SYNTHESIS
`define UCR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define UCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define UCR_ASSERT_SAME(label, clk, rst, ante, cons)
`define UCR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/ucr_pkg.sv @@
// shared types and constants for the uart command recognizer
// no dependencies
package ucr_pkg;

   localparam int BUFFER_DEPTH_DEFAULT      = 64;
   localparam int MAX_EXTRA_COLOURS_DEFAULT = 7;
   localparam int INDEX_WIDTH               = 6;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_1     = 8'h31;
   localparam logic [7:0] CHAR_3     = 8'h33;
   localparam logic [7:0] CHAR_7     = 8'h37;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LE    = 8'h65;
   localparam logic [7:0] CHAR_LG    = 8'h67;
   localparam logic [7:0] CHAR_LN    = 8'h6e;
   localparam logic [7:0] CHAR_LR    = 8'h72;
   localparam logic [7:0] CHAR_LS    = 8'h73;
   localparam logic [7:0] CHAR_LT    = 8'h74;
   localparam logic [7:0] CHAR_LW    = 8'h77;
   localparam logic [7:0] CHAR_LY    = 8'h79;
   localparam logic [7:0] CHAR_LZ    = 8'h7a;

   typedef enum logic [3:0] {
      ST_START   = 4'd0,
      ST_NEW_N   = 4'd1,
      ST_NEW_E   = 4'd2,
      ST_NEW_W   = 4'd3,
      ST_NEW_SP  = 4'd4,
      ST_COLOURS = 4'd5,
      ST_PERIOD  = 4'd6,
      ST_SET_S   = 4'd7,
      ST_SET_E   = 4'd8,
      ST_SET_T   = 4'd9,
      ST_SET_SP  = 4'd10,
      ST_TEXT    = 4'd11
   } parse_state_type;

   typedef enum logic [2:0] {
      RES_OK      = 3'd0,
      RES_UNKNOWN = 3'd1,
      RES_CREATE  = 3'd2,
      RES_PERIOD  = 3'd3,
      RES_CHANGE  = 3'd4,
      RES_TEXT    = 3'd5
   } result_code_type;

   typedef struct packed {
      result_code_type        result_code;
      logic                   store_valid;
      logic [7:0]             store_char;
      logic [INDEX_WIDTH-1:0] store_index;
      logic                   buffer_overflow;
   } rsp_item_type;

   function automatic logic is_colour(input logic [7:0] c);
      return (c == CHAR_LG) || (c == CHAR_LR) || (c == CHAR_LY) || (c == CHAR_LN);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= CHAR_LA) && (c <= CHAR_LZ);
   endfunction

endpackage

@@ rtl/ucr_req_stage.sv @@
// input register of the uart command recognizer
// holds one request until the parse stage can take it; uses ucr_pkg
module ucr_req_stage
   import ucr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_symbol,
   input  logic       req_clear_before,
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_symbol,
   output logic       item_clear_before
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] symbol_ff;
   logic       clear_ff;
   logic       load;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         symbol_ff <= req_symbol;
         clear_ff  <= req_clear_before;
      end
   end

   assign item_valid        = valid_ff;
   assign item_symbol       = symbol_ff;
   assign item_clear_before = clear_ff;

endmodule

@@ rtl/ucr_parser.sv @@
// command parser: state register, colour counter, buffer fill count and
// the combinational step logic; uses ucr_pkg and the assertion macros
`include "uart_command_recognizer_macros.svh"
module ucr_parser
   import ucr_pkg::*;
#(
   parameter int BUFFER_DEPTH      = BUFFER_DEPTH_DEFAULT,
   parameter int MAX_EXTRA_COLOURS = MAX_EXTRA_COLOURS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic [7:0]   symbol,
   input  logic         clear_before,
   output rsp_item_type result
);

   localparam int FILL_WIDTH = $clog2(BUFFER_DEPTH + 1);
   localparam logic [FILL_WIDTH-1:0] FILL_FULL = FILL_WIDTH'(BUFFER_DEPTH);
   localparam logic [2:0] EXTRA_MAX = 3'(MAX_EXTRA_COLOURS);

   parse_state_type       state_ff;
   parse_state_type       state_in;
   logic [2:0]            extra_ff;
   logic [2:0]            extra_in;
   logic [FILL_WIDTH-1:0] fill_ff;
   logic [FILL_WIDTH-1:0] fill_in;
   logic [FILL_WIDTH-1:0] fill_base;
   logic                  want_append;
   logic                  fail;
   logic                  done;
   logic                  full;
   result_code_type       res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         extra_ff <= '0;
         fill_ff  <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         extra_ff <= extra_in;
         fill_ff  <= fill_in;
      end
   end

   assign fill_base = clear_before ? '0 : fill_ff;
   assign full      = fill_base >= FILL_FULL;

   always_comb begin
      state_in    = state_ff;
      extra_in    = extra_ff;
      res         = RES_OK;
      done        = 1'b0;
      fail        = 1'b0;
      want_append = 1'b0;
      unique case (state_ff)
         ST_START: begin
            if (symbol == CHAR_LN) state_in = ST_NEW_N;
            else if (symbol == CHAR_LS) state_in = ST_SET_S;
            else fail = 1'b1;
         end
         ST_NEW_N: begin
            if (symbol == CHAR_LE) state_in = ST_NEW_E;
            else fail = 1'b1;
         end
         ST_NEW_E: begin
            if (symbol == CHAR_LW) state_in = ST_NEW_W;
            else fail = 1'b1;
         end
         ST_NEW_W: begin
            if (symbol == CHAR_SPACE) state_in = ST_NEW_SP;
            else fail = 1'b1;
         end
         ST_NEW_SP: begin
            if (is_colour(symbol)) begin
               state_in    = ST_COLOURS;
               want_append = 1'b1;
            end else fail = 1'b1;
         end
         ST_COLOURS: begin
            if (symbol == CHAR_CR) begin
               extra_in = '0;
               state_in = ST_PERIOD;
               res      = RES_CREATE;
               done     = 1'b1;
            end else if (is_colour(symbol)) begin
               want_append = 1'b1;
               extra_in    = extra_ff + 3'd1;
            end else fail = 1'b1;
         end
         ST_PERIOD: begin
            if (symbol >= CHAR_1 && symbol <= CHAR_3) begin
               state_in    = ST_START;
               want_append = 1'b1;
               res         = RES_PERIOD;
               done        = 1'b1;
            end else fail = 1'b1;
         end
         ST_SET_S: begin
            if (symbol == CHAR_LE) state_in = ST_SET_E;
            else fail = 1'b1;
         end
         ST_SET_E: begin
            if (symbol == CHAR_LT) state_in = ST_SET_T;
            else fail = 1'b1;
         end
         ST_SET_T: begin
            if (symbol == CHAR_SPACE) state_in = ST_SET_SP;
            else fail = 1'b1;
         end
         ST_SET_SP: begin
            if (symbol >= CHAR_0 && symbol <= CHAR_7) begin
               state_in    = ST_START;
               want_append = 1'b1;
               res         = RES_CHANGE;
               done        = 1'b1;
            end else if (is_lower(symbol)) begin
               state_in    = ST_TEXT;
               want_append = 1'b1;
            end else fail = 1'b1;
         end
         ST_TEXT: begin
            if (symbol == CHAR_CR) begin
               state_in = ST_START;
               res      = RES_TEXT;
               done     = 1'b1;
            end else if (is_lower(symbol) || symbol == CHAR_SPACE) begin
               want_append = 1'b1;
            end else fail = 1'b1;
         end
         default: fail = 1'b1;
      endcase

      if (fail) begin
         state_in = ST_START;
         extra_in = '0;
         res      = RES_UNKNOWN;
         done     = 1'b1;
      end

      // eighth colour closes the scheme at once
      if (!done && extra_in >= EXTRA_MAX) begin
         extra_in = '0;
         state_in = ST_PERIOD;
         res      = RES_CREATE;
      end

      if (fail) fill_in = '0;
      else if (want_append && !full) fill_in = fill_base + 1'b1;
      else fill_in = fill_base;

      result.result_code     = res;
      result.store_valid     = want_append && !full;
      result.store_char      = (want_append && !full) ? symbol : 8'd0;
      result.store_index     = (want_append && !full) ? INDEX_WIDTH'(fill_base) : '0;
      result.buffer_overflow = want_append && full;
   end

   `UCR_ASSERT_SAME(a_unknown_no_store, clock, reset, fire && result.result_code == RES_UNKNOWN, !result.store_valid && !result.buffer_overflow)
   `UCR_ASSERT_NEXT(a_unknown_restart, clock, reset, fire && result.result_code == RES_UNKNOWN, state_ff == ST_START && extra_ff == 3'd0 && fill_ff == '0)
   `UCR_ASSERT_NEXT(a_store_counts, clock, reset, fire && result.store_valid && !clear_before, fill_ff == $past(fill_ff) + 1'b1)
   `UCR_ASSERT_NEXT(a_create_waits_period, clock, reset, fire && result.result_code == RES_CREATE, state_ff == ST_PERIOD && extra_ff == 3'd0)

endmodule

@@ rtl/ucr_rsp_stage.sv @@
// result register of the uart command recognizer
// holds one response while the receiver stalls; uses ucr_pkg
module ucr_rsp_stage
   import ucr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  rsp_item_type item,
   output logic         advance,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [2:0]   rsp_result_code,
   output logic         rsp_store_valid,
   output logic [7:0]   rsp_store_char,
   output logic [5:0]   rsp_store_index,
   output logic         rsp_buffer_overflow
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   logic         open;

   assign open     = !valid_ff || !rsp_stall;
   assign advance  = item_valid && open;
   assign valid_in = open ? item_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_result_code     = item_ff.result_code;
   assign rsp_store_valid     = item_ff.store_valid;
   assign rsp_store_char      = item_ff.store_char;
   assign rsp_store_index     = item_ff.store_index;
   assign rsp_buffer_overflow = item_ff.buffer_overflow;

endmodule

@@ rtl/uart_command_recognizer.sv @@
// uart command recognizer, top level
// request channel (req_*): one received byte and a clear flag per request
// response channel (rsp_*): exactly one response per request, in order
// "new " plus colour letters g r y n reports create scheme on carriage return
// or on the eighth colour, then expects a period digit 1..3; "set " plus one
// digit 0..7 reports a scheme change, "set " plus lower-case text and
// carriage return reports a text line; stored bytes come with their index
// the response is valid once its request has passed the input register and
// then the result register, which waits while a stalled response holds it
// one request per cycle while no response stalls, since the parse step
// between the input register and the result register is combinational
// a stalled response holds; the input register still takes one request,
// after which req_stall follows rsp_stall
// reset clears the valid flags of both stages, the parse state, colour count and fill count
// depends on ucr_pkg, ucr_req_stage, ucr_parser, ucr_rsp_stage
module uart_command_recognizer
   import ucr_pkg::*;
#(
   parameter int BUFFER_DEPTH      = BUFFER_DEPTH_DEFAULT,
   parameter int MAX_EXTRA_COLOURS = MAX_EXTRA_COLOURS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_symbol,
   input  logic       req_clear_before,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_result_code,
   output logic       rsp_store_valid,
   output logic [7:0] rsp_store_char,
   output logic [5:0] rsp_store_index,
   output logic       rsp_buffer_overflow
);

   logic         item_valid;
   logic [7:0]   item_symbol;
   logic         item_clear_before;
   logic         advance;
   rsp_item_type parse_result;

   ucr_req_stage u_req_stage (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_symbol        (req_symbol),
      .req_clear_before  (req_clear_before),
      .advance           (advance),
      .item_valid        (item_valid),
      .item_symbol       (item_symbol),
      .item_clear_before (item_clear_before)
   );

   ucr_parser #(
      .BUFFER_DEPTH      (BUFFER_DEPTH),
      .MAX_EXTRA_COLOURS (MAX_EXTRA_COLOURS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .symbol       (item_symbol),
      .clear_before (item_clear_before),
      .result       (parse_result)
   );

   ucr_rsp_stage u_rsp_stage (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (item_valid),
      .item                (parse_result),
      .advance             (advance),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_code     (rsp_result_code),
      .rsp_store_valid     (rsp_store_valid),
      .rsp_store_char      (rsp_store_char),
      .rsp_store_index     (rsp_store_index),
      .rsp_buffer_overflow (rsp_buffer_overflow)
   );

endmodule
